/* rtl/irpfd_pkg.sv */
// Shared types and constants for the IR pulse frame decoder.
// No dependencies; every other file imports this package.
package irpfd_pkg;

	localparam int unsigned WidthW   = 16;
	localparam int unsigned CodeW    = 32;
	localparam int unsigned CmdW     = 8;
	localparam int unsigned ActW     = 4;
	localparam int unsigned KeyW     = 4;
	localparam int unsigned BitCntW  = 5;
	localparam int unsigned CmdLsb   = 8;

	// Pulse width windows, in timer ticks (inclusive)
	localparam logic [WidthW-1:0] StartLo  = 16'd1236;
	localparam logic [WidthW-1:0] StartHi  = 16'd1444;
	localparam logic [WidthW-1:0] ZeroLo   = 16'd80;
	localparam logic [WidthW-1:0] ZeroHi   = 16'd160;
	localparam logic [WidthW-1:0] OneLo    = 16'd180;
	localparam logic [WidthW-1:0] OneHi    = 16'd250;
	localparam logic [WidthW-1:0] GapALo   = 16'd3500;
	localparam logic [WidthW-1:0] GapAHi   = 16'd4500;
	localparam logic [WidthW-1:0] GapBLo   = 16'd9350;
	localparam logic [WidthW-1:0] GapBHi   = 16'd9820;
	localparam logic [WidthW-1:0] RptLo    = 16'd1110;
	localparam logic [WidthW-1:0] RptHi    = 16'd1130;

	localparam logic [BitCntW-1:0] LastBit = 5'd31;

	typedef enum logic [ActW-1:0] {
		ACT_TOGGLE     = 4'd0,
		ACT_VOLTAGE    = 4'd1,
		ACT_TEMP_CLOCK = 4'd2,
		ACT_DATE       = 4'd3,
		ACT_TEMP       = 4'd4,
		ACT_COUNTER    = 4'd5,
		ACT_POMO       = 4'd6,
		ACT_POMO_BREAK = 4'd7,
		ACT_POMO_REST  = 4'd8,
		ACT_KEY        = 4'd9,
		ACT_PRESS      = 4'd10,
		ACT_INVALID    = 4'd11
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BITS,
		ST_GAP
	} state_t;

	// Which windows a pulse width falls in
	typedef struct packed {
		logic is_start;
		logic is_zero;
		logic is_one;
		logic is_gap;
		logic is_rpt;
	} width_class_t;

	// Decoded command byte
	typedef struct packed {
		action_t             action;
		logic [KeyW-1:0]     key_value;
	} cmd_dec_t;

endpackage

/* rtl/irpfd_pulse_if.sv */
// Request channel carrying one measured pulse width.
// Depends on irpfd_pkg.
interface irpfd_pulse_if import irpfd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WidthW-1:0] pulse_width;

	modport source (output valid, output pulse_width, input ready);
	modport sink   (input valid, input pulse_width, output ready);
endinterface

/* rtl/irpfd_result_if.sv */
// Result channel carrying one decoded event.
// Depends on irpfd_pkg.
interface irpfd_result_if import irpfd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ActW-1:0]  action;
	logic [KeyW-1:0]  key_value;
	logic [CmdW-1:0]  command_byte;
	logic [CodeW-1:0] frame_code;

	modport source (output valid, output action, output key_value, output command_byte,
		output frame_code, input ready);
	modport sink   (input valid, input action, input key_value, input command_byte,
		input frame_code, output ready);
endinterface

/* rtl/irpfd_width_class.sv */
// Pulse width window compares; feeds the input register.
// Depends on irpfd_pkg.
module irpfd_width_class import irpfd_pkg::*; (
	input  logic [WidthW-1:0] width,
	output width_class_t      cls
);

	// Inclusive window checks
	always_comb begin
		cls.is_start = (width >= StartLo) && (width <= StartHi);
		cls.is_zero  = (width >= ZeroLo)  && (width <= ZeroHi);
		cls.is_one   = (width >= OneLo)   && (width <= OneHi);
		cls.is_gap   = ((width >= GapALo) && (width <= GapAHi)) ||
		               ((width >= GapBLo) && (width <= GapBHi));
		cls.is_rpt   = (width >= RptLo)   && (width <= RptHi);
	end

endmodule

/* rtl/irpfd_cmd_map.sv */
// Fixed command byte table: byte to action code and key digit.
// Depends on irpfd_pkg.
module irpfd_cmd_map import irpfd_pkg::*; (
	input  logic [CmdW-1:0] cmd,
	output cmd_dec_t        dec
);

	// Unknown bytes decode as invalid
	always_comb begin
		dec.key_value = '0;
		case (cmd)
			8'hA2: dec.action = ACT_TOGGLE;
			8'h62: dec.action = ACT_VOLTAGE;
			8'hE2: dec.action = ACT_TEMP_CLOCK;
			8'h22: dec.action = ACT_DATE;
			8'h02: dec.action = ACT_TEMP;
			8'hC2: dec.action = ACT_COUNTER;
			8'hE0: dec.action = ACT_POMO;
			8'hA8: dec.action = ACT_POMO_BREAK;
			8'h90: dec.action = ACT_POMO_REST;
			8'h68: dec.action = ACT_KEY;
			8'h98: begin dec.action = ACT_KEY; dec.key_value = 4'd10; end
			8'hB0: begin dec.action = ACT_KEY; dec.key_value = 4'd11; end
			8'h30: begin dec.action = ACT_KEY; dec.key_value = 4'd1; end
			8'h18: begin dec.action = ACT_KEY; dec.key_value = 4'd2; end
			8'h7A: begin dec.action = ACT_KEY; dec.key_value = 4'd3; end
			8'h10: begin dec.action = ACT_KEY; dec.key_value = 4'd4; end
			8'h38: begin dec.action = ACT_KEY; dec.key_value = 4'd5; end
			8'h5A: begin dec.action = ACT_KEY; dec.key_value = 4'd6; end
			8'h42: begin dec.action = ACT_KEY; dec.key_value = 4'd7; end
			8'h4A: begin dec.action = ACT_KEY; dec.key_value = 4'd8; end
			8'h52: begin dec.action = ACT_KEY; dec.key_value = 4'd9; end
			default: dec.action = ACT_INVALID;
		endcase
	end

endmodule

/* rtl/ir_pulse_frame_decoder_core.sv */
// IR pulse frame decoder top level: input register, frame state machine, result register.
// Depends on irpfd_pkg, irpfd_pulse_if, irpfd_result_if, irpfd_width_class, irpfd_cmd_map.
//
// Takes one pulse width per request and accepts a new request every clock cycle while pulse
// ready is high. A width is classified into its windows as it enters the input register;
// the frame state machine then consumes it from there and, when a frame or repeat completes,
// loads the result register. Pulse ready drops only while the result register holds an
// untaken result and the input register is full.
module ir_pulse_frame_decoder_core import irpfd_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	irpfd_pulse_if.sink    pulse,
	irpfd_result_if.source result
);

	width_class_t      cls_in;
	width_class_t      cls_s1;
	logic              valid_s1;
	logic              adv;

	state_t            state_q, state_d;
	logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
	logic [CodeW-1:0]  shift_q, shift_d;
	logic              rep_q, rep_d;
	logic              emit_frame, emit_press;

	cmd_dec_t          dec;

	logic              out_valid_q;
	action_t           out_action_q;
	logic [KeyW-1:0]   out_key_q;
	logic [CodeW-1:0]  out_code_q;

	irpfd_width_class u_class (
		.width (pulse.pulse_width),
		.cls   (cls_in)
	);

	// Stage 1 moves on whenever the result register is free or being emptied
	assign adv         = !out_valid_q || result.ready;
	assign pulse.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pulse.ready) begin
			valid_s1 <= pulse.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pulse.ready && pulse.valid) begin
			cls_s1 <= cls_in;
		end
	end

	// Next state of the frame machine
	always_comb begin
		state_d   = state_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		rep_d     = rep_q;
		case (state_q)
			ST_IDLE: begin
				if (cls_s1.is_start) begin
					state_d   = ST_BITS;
					bit_cnt_d = '0;
					shift_d   = '0;
					rep_d     = 1'b0;
				end else if (rep_q && cls_s1.is_gap) begin
					state_d = ST_GAP;
				end else begin
					rep_d = 1'b0;
				end
			end
			ST_BITS: begin
				if (cls_s1.is_zero || cls_s1.is_one) begin
					shift_d = {shift_q[CodeW-2:0], cls_s1.is_one};
					if (bit_cnt_q == LastBit) begin
						state_d   = ST_IDLE;
						bit_cnt_d = '0;
						rep_d     = 1'b1;
					end else begin
						bit_cnt_d = bit_cnt_q + 1'b1;
					end
				end else begin
					state_d   = ST_IDLE;
					bit_cnt_d = '0;
				end
			end
			ST_GAP: begin
				state_d = ST_IDLE;
				if (cls_s1.is_rpt) begin
					rep_d = 1'b1;
				end
			end
			default: begin
				state_d   = ST_IDLE;
				bit_cnt_d = '0;
			end
		endcase
	end

	// Result strobes of the frame machine
	always_comb begin
		emit_frame = 1'b0;
		emit_press = 1'b0;
		case (state_q)
			ST_BITS: emit_frame = (cls_s1.is_zero || cls_s1.is_one) && (bit_cnt_q == LastBit);
			ST_GAP:  emit_press = cls_s1.is_rpt;
			default: begin
				emit_frame = 1'b0;
				emit_press = 1'b0;
			end
		endcase
	end

	irpfd_cmd_map u_cmd (
		.cmd (shift_d[CmdLsb +: CmdW]),
		.dec (dec)
	);

	// Frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			shift_q   <= '0;
			rep_q     <= 1'b0;
		end else if (valid_s1 && adv) begin
			state_q   <= state_d;
			bit_cnt_q <= bit_cnt_d;
			shift_q   <= shift_d;
			rep_q     <= rep_d;
		end
	end

	// Result register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && (emit_frame || emit_press);
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (adv && valid_s1 && (emit_frame || emit_press)) begin
			out_action_q <= emit_press ? ACT_PRESS : dec.action;
			out_key_q    <= emit_press ? '0 : dec.key_value;
			out_code_q   <= shift_d;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.action       = out_action_q;
	assign result.key_value    = out_key_q;
	assign result.command_byte = out_code_q[CmdLsb +: CmdW];
	assign result.frame_code   = out_code_q;

	// A new result always comes from an item that sat in stage 1
	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a stage-1 item");

	// The gap state is only reachable with the repeat flag armed
	a_gap_needs_rep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GAP) |-> rep_q)
		else $error("gap state without repeat flag");

	// Bit counter is parked at zero outside a frame
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_BITS) |-> (bit_cnt_q == '0))
		else $error("bit counter nonzero outside frame");

	// Key digit is only carried by key results
	a_key_only_on_key: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_key_q != '0) |-> (out_action_q == ACT_KEY))
		else $error("key value on non-key result");

	// A completed frame always arms the repeat flag
	a_frame_arms_rep: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv && emit_frame) |=> rep_q)
		else $error("repeat flag not armed after frame");

endmodule
